// File: rtl/core/dsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types, codes and pattern helpers of the delimiter stream deframer.
// ----------------------------------------------------------------------------
package dsd_pkg;

	localparam int DelimLen = 6;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_FRAME    = 2'd1,
		KIND_TOO_LONG = 2'd2,
		KIND_CLOSED   = 2'd3
	} kind_t;

	typedef enum logic {
		REQ_DATA  = 1'b0,
		REQ_CLOSE = 1'b1
	} req_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       hit;
		logic       complete;
		logic [2:0] m_eff;
		logic [2:0] next_m;
		logic [2:0] keep;
		logic [2:0] rel;
	} match_info_t;

	function automatic logic [7:0] pat_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0, 3'd1, 3'd4, 3'd5: b = 8'h23;
			3'd2, 3'd3:             b = 8'h2F;
			default:                b = 8'h00;
		endcase
		return b;
	endfunction

	// Longest proper tail of the held prefix plus the new byte that is itself
	// a delimiter prefix.
	function automatic logic [2:0] tail_len(input logic [2:0] m, input logic [7:0] c);
		logic [7:0] seq [DelimLen];
		logic [2:0] k;
		logic       ok;
		logic       found;
		int         base;
		k     = '0;
		found = 1'b0;
		for (int i = 0; i < DelimLen; i++) begin
			seq[i] = (i < int'(m)) ? pat_byte(3'(i)) : c;
		end
		for (int kk = DelimLen - 1; kk > 0; kk--) begin
			if (!found && kk <= int'(m)) begin
				ok   = 1'b1;
				base = int'(m) + 1 - kk;
				for (int i = 0; i < kk; i++) begin
					if (seq[base + i] != pat_byte(3'(i)))
						ok = 1'b0;
				end
				if (ok) begin
					found = 1'b1;
					k     = 3'(kk);
				end
			end
		end
		return k;
	endfunction

endpackage

// File: rtl/core/delimiter_stream_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimiter_stream_deframer
// Splits a byte stream into frames ended by the delimiter "##//##".
// ----------------------------------------------------------------------------
// A byte that is held or ends a frame, and a close request, are taken without entering the release state.
// A broken partial match releases one byte per cycle, unless the output stalls,
// through the shared length compare and counter: rel bytes, rel from 1 to 6.
// Results are registered before they appear on the outputs.
// Reset clears the held count, the payload count and the output valid, and
// sets max_length to 10000.
module delimiter_stream_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [15:0] frame_length,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	dsd_pkg::state_t      state_q, state_next;
	dsd_pkg::match_info_t info;

	logic [15:0] max_length_q;
	logic [2:0]  match_count_q;
	logic [15:0] payload_count_q;
	logic [2:0]  m_q, keep_q, rel_q, idx_q;
	logic [7:0]  c_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  out_byte_q;
	logic [15:0] frame_length_q;
	logic        last_q;

	logic in_accept, out_free, too_long, emit_last, emit_step;

	dsd_match u_match (
		.match_count(match_count_q),
		.in_byte    (in_byte),
		.info       (info)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign too_long  = (payload_count_q >= max_length_q);
	assign emit_last = (idx_q == rel_q - 3'd1);
	assign in_accept = in_valid && !in_stall;
	assign emit_step = (state_q == dsd_pkg::ST_EMIT) && out_free;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			dsd_pkg::ST_IDLE: begin
				if (in_accept && req_type == dsd_pkg::REQ_DATA && !info.hit)
					state_next = dsd_pkg::ST_EMIT;
			end
			dsd_pkg::ST_EMIT: begin
				if (out_free && (too_long || emit_last))
					state_next = dsd_pkg::ST_IDLE;
			end
			default: state_next = dsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			dsd_pkg::ST_IDLE: in_stall = out_valid_q && out_stall;
			dsd_pkg::ST_EMIT: in_stall = 1'b1;
			default:          in_stall = 1'b1;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= dsd_pkg::ST_IDLE;
			max_length_q    <= 16'd10000;
			match_count_q   <= '0;
			payload_count_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready)
				max_length_q <= cfg_data;
			if (in_accept) begin
				if (req_type == dsd_pkg::REQ_CLOSE || info.complete) begin
					match_count_q   <= '0;
					payload_count_q <= '0;
					out_valid_q     <= 1'b1;
				end else begin
					if (info.hit)
						match_count_q <= info.next_m;
					if (!out_stall)
						out_valid_q <= 1'b0;
				end
			end else if (emit_step) begin
				out_valid_q <= 1'b1;
				if (too_long) begin
					match_count_q   <= '0;
					payload_count_q <= '0;
				end else begin
					payload_count_q <= payload_count_q + 16'd1;
					if (emit_last)
						match_count_q <= keep_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			m_q    <= info.m_eff;
			keep_q <= info.keep;
			rel_q  <= info.rel;
			c_q    <= in_byte;
			idx_q  <= '0;
			kind_q         <= (req_type == dsd_pkg::REQ_CLOSE) ? dsd_pkg::KIND_CLOSED
			                                                   : dsd_pkg::KIND_FRAME;
			out_byte_q     <= '0;
			frame_length_q <= payload_count_q;
			last_q         <= 1'b1;
		end else if (emit_step) begin
			idx_q <= idx_q + 3'd1;
			if (too_long) begin
				kind_q         <= dsd_pkg::KIND_TOO_LONG;
				out_byte_q     <= '0;
				frame_length_q <= '0;
				last_q         <= 1'b1;
			end else begin
				kind_q         <= dsd_pkg::KIND_PAYLOAD;
				out_byte_q     <= (idx_q < m_q) ? dsd_pkg::pat_byte(idx_q) : c_q;
				frame_length_q <= '0;
				last_q         <= emit_last;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign out_byte     = out_byte_q;
	assign frame_length = frame_length_q;
	assign last         = last_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsd_pkg::ST_EMIT |-> in_stall)
		else $error("input not stalled while releasing bytes");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		match_count_q < 3'(dsd_pkg::DelimLen))
		else $error("held count out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsd_pkg::ST_EMIT |-> idx_q < rel_q)
		else $error("release index past release count");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != dsd_pkg::KIND_PAYLOAD |-> last_q)
		else $error("frame event result not marked last");

endmodule

// File: rtl/core/dsd_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_match
// Compares a received byte against the delimiter and works out how many
// bytes are released on a broken partial match.
// ----------------------------------------------------------------------------
module dsd_match (
	input  logic [2:0]           match_count,
	input  logic [7:0]           in_byte,
	output dsd_pkg::match_info_t info
);

	logic [2:0] m_eff;
	logic [2:0] keep;

	assign m_eff = (match_count >= 3'(dsd_pkg::DelimLen)) ? 3'd0 : match_count;
	assign keep  = dsd_pkg::tail_len(m_eff, in_byte);

	always_comb begin
		info.hit      = (in_byte == dsd_pkg::pat_byte(m_eff));
		info.complete = info.hit && (m_eff == 3'(dsd_pkg::DelimLen - 1));
		info.m_eff    = m_eff;
		info.next_m   = m_eff + 3'd1;
		info.keep     = keep;
		info.rel      = m_eff + 3'd1 - keep;
	end

endmodule
